@@ rtl/gha_pkg.sv @@
package gha_pkg;

  localparam int unsigned DefaultSlots        = 64;
  localparam int unsigned DefaultGenWidth     = 16;
  localparam int unsigned DefaultPayloadWidth = 32;

  localparam int unsigned ModeWidth   = 2;
  localparam int unsigned StatusWidth = 2;

  typedef enum logic [ModeWidth-1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_LOOKUP = 2'd1,
    MODE_DROP   = 2'd2,
    MODE_CLEAR  = 2'd3
  } mode_e;

  typedef enum logic [StatusWidth-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_STALE = 2'd2,
    ST_NULL  = 2'd3
  } status_e;

  // write enables of the slot store
  typedef struct packed {
    logic pay_we;
    logic gen_we;
  } store_wr_t;

endpackage

@@ rtl/gha_slot_store.sv @@
module gha_slot_store #(
  parameter int unsigned SLOTS         = gha_pkg::DefaultSlots,
  parameter int unsigned GEN_WIDTH     = gha_pkg::DefaultGenWidth,
  parameter int unsigned PAYLOAD_WIDTH = gha_pkg::DefaultPayloadWidth,
  localparam int unsigned IdxW         = $clog2(SLOTS)
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [IdxW-1:0]          rd_addr_i,
  output logic [PAYLOAD_WIDTH-1:0] rd_pay_o,
  output logic [GEN_WIDTH-1:0]     rd_gen_o,
  input  gha_pkg::store_wr_t       wr_i,
  input  logic [IdxW-1:0]          wr_addr_i,
  input  logic [PAYLOAD_WIDTH-1:0] wr_pay_i,
  input  logic [GEN_WIDTH-1:0]     wr_gen_i
);

  logic [PAYLOAD_WIDTH-1:0] pay_mem [SLOTS];
  logic [GEN_WIDTH-1:0]     gen_mem [SLOTS];

  always_ff @(posedge clk_i) begin
    if (wr_i.pay_we) begin
      pay_mem[wr_addr_i] <= wr_pay_i;
    end
    if (wr_i.gen_we) begin
      gen_mem[wr_addr_i] <= wr_gen_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_pay_o <= pay_mem[rd_addr_i];
      rd_gen_o <= gen_mem[rd_addr_i];
    end
  end

endmodule

@@ rtl/generational_handle_allocator_core.sv @@
// Generational handle table: allocate, lookup, drop and clear over a stream.
// In each transaction the accept edge issues the synchronous
// read of the slot memories and of the free stack top, then the execute state
// checks the handle, writes the memories and loads the result register.
// A new transaction can be accepted in the cycle after the previous one completes;
// a result waiting on m_axis_tready holds the transaction in the execute state
// and so delays the next accept. Handles are
// (index, generation); index 0 is reserved so an all-zero handle is null.
// Freed slots are reused last-in first-out. Clear takes effect in one
// transaction with no sweep of the memories. The status field travels on
// tuser.
module generational_handle_allocator_core #(
  parameter int unsigned SLOTS         = gha_pkg::DefaultSlots,
  parameter int unsigned GEN_WIDTH     = gha_pkg::DefaultGenWidth,
  parameter int unsigned PAYLOAD_WIDTH = gha_pkg::DefaultPayloadWidth,
  localparam int unsigned IdxW         = $clog2(SLOTS),
  localparam int unsigned DataW        = ((IdxW + GEN_WIDTH + PAYLOAD_WIDTH + 7) / 8) * 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // slot_index, handle_gen, payload, zero fill
  input  logic [DataW-1:0]                s_axis_tdata,
  // mode
  input  logic [gha_pkg::ModeWidth-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // out_index, out_gen, out_payload, zero fill
  output logic [DataW-1:0]                m_axis_tdata,
  // status
  output logic [gha_pkg::StatusWidth-1:0] m_axis_tuser
);

  localparam int unsigned CntW = $clog2(SLOTS + 1);
  localparam int unsigned FsW  = IdxW + GEN_WIDTH;
  localparam int unsigned PadW = DataW - IdxW - GEN_WIDTH - PAYLOAD_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_e;

  state_e state_q, state_d;

  logic                     accept;
  logic                     fire;

  gha_pkg::mode_e           mode_q;
  logic [IdxW-1:0]          idx_q;
  logic [GEN_WIDTH-1:0]     gen_q;
  logic [PAYLOAD_WIDTH-1:0] pay_q;

  logic [CntW-1:0]          free_count_q, free_count_d;
  logic [CntW-1:0]          high_water_q, high_water_d;

  logic [FsW-1:0]           fs_mem [SLOTS];
  logic [FsW-1:0]           fs_top_q;
  logic                     fs_we;
  logic [FsW-1:0]           fs_wdata;

  logic [PAYLOAD_WIDTH-1:0] rd_pay;
  logic [GEN_WIDTH-1:0]     rd_gen;
  gha_pkg::store_wr_t       st_wr;
  logic [IdxW-1:0]          st_addr;
  logic [PAYLOAD_WIDTH-1:0] st_pay;
  logic [GEN_WIDTH-1:0]     st_gen;

  logic                     live;
  logic [GEN_WIDTH-1:0]     gen_next;
  gha_pkg::status_e         res_status;
  logic [IdxW-1:0]          res_idx;
  logic [GEN_WIDTH-1:0]     res_gen;
  logic [PAYLOAD_WIDTH-1:0] res_pay;

  logic                     m_valid_q;
  gha_pkg::status_e         m_status_q;
  logic [IdxW-1:0]          m_idx_q;
  logic [GEN_WIDTH-1:0]     m_gen_q;
  logic [PAYLOAD_WIDTH-1:0] m_pay_q;

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign fire          = (state_q == S_EXEC) && (!m_valid_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_count_q <= '0;
      high_water_q <= CntW'(1);
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_count_q <= free_count_d;
      high_water_q <= high_water_d;
      if (fire) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q <= gha_pkg::mode_e'(s_axis_tuser);
      idx_q  <= s_axis_tdata[IdxW-1:0];
      gen_q  <= s_axis_tdata[IdxW +: GEN_WIDTH];
      pay_q  <= s_axis_tdata[IdxW + GEN_WIDTH +: PAYLOAD_WIDTH];
    end
    if (fire) begin
      m_status_q <= res_status;
      m_idx_q    <= res_idx;
      m_gen_q    <= res_gen;
      m_pay_q    <= res_pay;
    end
  end

  // free stack entries carry the index and the generation it will reuse
  always_ff @(posedge clk_i) begin
    if (fs_we) begin
      fs_mem[free_count_q[IdxW-1:0]] <= fs_wdata;
    end
    if (accept) begin
      fs_top_q <= fs_mem[IdxW'(free_count_q - CntW'(1))];
    end
  end

  gha_slot_store #(
    .SLOTS         (SLOTS),
    .GEN_WIDTH     (GEN_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_store (
    .clk_i     (clk_i),
    .rd_en_i   (accept),
    .rd_addr_i (s_axis_tdata[IdxW-1:0]),
    .rd_pay_o  (rd_pay),
    .rd_gen_o  (rd_gen),
    .wr_i      (st_wr),
    .wr_addr_i (st_addr),
    .wr_pay_i  (st_pay),
    .wr_gen_i  (st_gen)
  );

  assign live = (idx_q != '0) && (gen_q != '0) && (CntW'(idx_q) < high_water_q) &&
                (rd_gen == gen_q) && (rd_pay != '0);

  // wrap past zero to one
  always_comb begin
    gen_next = rd_gen + GEN_WIDTH'(1);
    if (gen_next == '0) begin
      gen_next = GEN_WIDTH'(1);
    end
  end

  always_comb begin
    res_status   = gha_pkg::ST_OK;
    res_idx      = idx_q;
    res_gen      = '0;
    res_pay      = '0;
    free_count_d = free_count_q;
    high_water_d = high_water_q;
    st_wr        = '0;
    st_addr      = idx_q;
    st_pay       = pay_q;
    st_gen       = gen_next;
    fs_we        = 1'b0;
    fs_wdata     = {idx_q, gen_next};
    case (mode_q)
      gha_pkg::MODE_ALLOC: begin
        if (pay_q == '0) begin
          res_status = gha_pkg::ST_NULL;
        end else if (free_count_q != '0) begin
          res_idx         = fs_top_q[FsW-1 -: IdxW];
          res_gen         = fs_top_q[GEN_WIDTH-1:0];
          st_addr         = fs_top_q[FsW-1 -: IdxW];
          st_wr.pay_we    = fire;
          free_count_d    = fire ? free_count_q - CntW'(1) : free_count_q;
        end else if (high_water_q < CntW'(SLOTS)) begin
          res_idx         = high_water_q[IdxW-1:0];
          res_gen         = GEN_WIDTH'(1);
          st_addr         = high_water_q[IdxW-1:0];
          st_gen          = GEN_WIDTH'(1);
          st_wr.pay_we    = fire;
          st_wr.gen_we    = fire;
          high_water_d    = fire ? high_water_q + CntW'(1) : high_water_q;
        end else begin
          res_status = gha_pkg::ST_FULL;
        end
      end
      gha_pkg::MODE_LOOKUP: begin
        if (live) begin
          res_pay = rd_pay;
        end else begin
          res_status = gha_pkg::ST_STALE;
        end
      end
      gha_pkg::MODE_DROP: begin
        if (live) begin
          st_pay       = '0;
          st_wr.pay_we = fire;
          st_wr.gen_we = fire;
          if (free_count_q < CntW'(SLOTS)) begin
            fs_we        = fire;
            free_count_d = fire ? free_count_q + CntW'(1) : free_count_q;
          end
        end else begin
          res_status = gha_pkg::ST_STALE;
        end
      end
      gha_pkg::MODE_CLEAR: begin
        if (fire) begin
          free_count_d = '0;
          high_water_d = CntW'(1);
        end
      end
      default: begin
        res_status = gha_pkg::ST_OK;
      end
    endcase
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, m_pay_q, m_gen_q, m_idx_q};

endmodule

@@ tb/tb.sv @@
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gha_pkg::*;

  localparam int unsigned Slots      = DefaultSlots;
  localparam int unsigned IdxW       = $clog2(Slots);
  localparam int unsigned GenW       = DefaultGenWidth;
  localparam int unsigned PayW       = DefaultPayloadWidth;
  localparam int unsigned DataW      = ((IdxW + GenW + PayW + 7) / 8) * 8;
  localparam int unsigned PadW       = DataW - IdxW - GenW - PayW;
  localparam int unsigned IdlePct    = 12;
  localparam int unsigned CycleLimit = 100_000;
  localparam int unsigned GenSteps   = 16;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [GenW-1:0] gen_t;
  typedef logic [PayW-1:0] pay_t;

  typedef struct packed {
    status_e status;
    idx_t    index;
    gen_t    gen;
    pay_t    pay;
  } handle_rsp_t;

  logic                   clk_i    = 1'b0;
  logic                   rst_ni   = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [DataW-1:0]       s_tdata  = '0;
  logic [ModeWidth-1:0]   s_tuser  = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [DataW-1:0]       m_tdata;
  logic [StatusWidth-1:0] m_tuser;

  // table shadow: updated on every accepted request
  pay_t        slot_pay [Slots];
  gen_t        slot_gen [Slots];
  idx_t        free_stk [Slots];
  int unsigned free_cnt  = 0;
  int unsigned high_mark = 1;
  handle_rsp_t pending_results[$];

  bit          idle_on = 1'b1;
  int unsigned cycles, err_cnt, rsp_cnt, ok_cnt, full_cnt, stale_cnt, null_cnt, wrap_cnt;

  generational_handle_allocator_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("tb failed");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    m_tready <= !(idle_on && $urandom_range(99) < IdlePct);
  end

  function automatic bit handle_live(idx_t idx, gen_t g);
    return idx != '0 && g != '0 && 32'(idx) < high_mark && slot_gen[idx] == g &&
           slot_pay[idx] != '0;
  endfunction

  function automatic void table_apply(mode_e m, idx_t idx, gen_t g, pay_t p);
    handle_rsp_t r;
    idx_t        ix;
    gen_t        ng;
    r = '{status: ST_OK, index: idx, gen: '0, pay: '0};
    case (m)
      MODE_ALLOC: begin
        if (p == '0) begin
          r.status = ST_NULL;
        end else if (free_cnt == 0 && high_mark >= Slots) begin
          r.status = ST_FULL;
        end else begin
          if (free_cnt > 0) begin
            free_cnt--;
            ix = free_stk[idx_t'(free_cnt)];
          end else begin
            ix = idx_t'(high_mark);
            high_mark++;
            slot_gen[ix] = gen_t'(1);
          end
          slot_pay[ix] = p;
          r.index      = ix;
          r.gen        = slot_gen[ix];
        end
      end
      MODE_LOOKUP: begin
        if (handle_live(idx, g)) r.pay = slot_pay[idx];
        else r.status = ST_STALE;
      end
      MODE_DROP: begin
        if (handle_live(idx, g)) begin
          ng = slot_gen[idx] + gen_t'(1);
          // generation zero is the null handle: skip it
          if (ng == '0) begin
            ng = gen_t'(1);
            wrap_cnt++;
          end
          slot_pay[idx] = '0;
          slot_gen[idx] = ng;
          if (free_cnt < Slots) begin
            free_stk[idx_t'(free_cnt)] = idx;
            free_cnt++;
          end
        end else begin
          r.status = ST_STALE;
        end
      end
      default: begin
        free_cnt  = 0;
        high_mark = 1;
      end
    endcase
    pending_results.push_back(r);
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    err_cnt++;
    $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
  endtask

  always @(posedge clk_i) begin : check_results
    handle_rsp_t got;
    handle_rsp_t want;
    if (rst_ni && m_tvalid && m_tready) begin
      got.status = status_e'(m_tuser);
      got.index  = m_tdata[IdxW-1:0];
      got.gen    = m_tdata[IdxW +: GenW];
      got.pay    = m_tdata[IdxW+GenW +: PayW];
      rsp_cnt++;
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", 64'(got), '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status) begin
          report_mismatch("status", 64'(got.status), 64'(want.status));
        end
        if (got.index != want.index) begin
          report_mismatch("out_index", 64'(got.index), 64'(want.index));
        end
        if (got.gen != want.gen) begin
          report_mismatch("out_gen", 64'(got.gen), 64'(want.gen));
        end
        if (got.pay != want.pay) begin
          report_mismatch("out_payload", 64'(got.pay), 64'(want.pay));
        end
        case (want.status)
          ST_OK:    ok_cnt++;
          ST_FULL:  full_cnt++;
          ST_STALE: stale_cnt++;
          default:  null_cnt++;
        endcase
      end
    end
  end

  // hold valid across back-to-back requests; lower it only in an idle cycle
  task automatic send_op(mode_e m, idx_t idx, gen_t g, pay_t p);
    while (idle_on && $urandom_range(99) < IdlePct) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= m;
    s_tdata  <= {{PadW{1'b0}}, p, g, idx};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    table_apply(m, idx, g, p);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic test_alloc_lookup();
    send_op(MODE_ALLOC, 6'h2A, 16'h1234, '0);        // null payload refused
    send_op(MODE_ALLOC, '0, '0, '1);                 // fresh slot 1
    send_op(MODE_ALLOC, '1, '1, pay_t'(1));          // fresh slot 2
    send_op(MODE_LOOKUP, idx_t'(1), gen_t'(1), '0);
    send_op(MODE_LOOKUP, idx_t'(2), gen_t'(1), '1);
    send_op(MODE_LOOKUP, '0, gen_t'(1), '0);          // reserved index
    send_op(MODE_LOOKUP, idx_t'(1), '0, '0);          // null handle
    send_op(MODE_LOOKUP, idx_t'(1), '1, '0);          // wrong generation
    send_op(MODE_LOOKUP, '1, gen_t'(1), '0);          // index not in use
    wait_drained();
  endtask

  task automatic test_drop_reuse();
    send_op(MODE_DROP, idx_t'(2), gen_t'(1), '0);
    send_op(MODE_LOOKUP, idx_t'(2), gen_t'(1), '0);   // stale after drop
    send_op(MODE_LOOKUP, idx_t'(2), gen_t'(2), '0);   // dead slot, generation matches
    send_op(MODE_DROP, idx_t'(2), gen_t'(2), '0);
    send_op(MODE_DROP, idx_t'(2), gen_t'(1), '0);
    send_op(MODE_DROP, '0, '0, '1);
    send_op(MODE_DROP, '1, gen_t'(1), '0);
    send_op(MODE_DROP, idx_t'(1), gen_t'(1), '0);
    send_op(MODE_ALLOC, '0, '0, 32'h8000_0000);      // reuses slot 1 first
    send_op(MODE_ALLOC, '0, '0, 32'h5A5A_A5A5);      // then slot 2
    send_op(MODE_ALLOC, '0, '0, 32'h0000_0100);      // then fresh slot 3
    wait_drained();
  endtask

  task automatic test_full_table();
    send_op(MODE_CLEAR, '1, '1, '1);
    repeat (Slots - 1) send_op(MODE_ALLOC, '0, '0, pay_t'($urandom) | pay_t'(1));
    send_op(MODE_ALLOC, '0, '0, pay_t'(7));          // table full
    send_op(MODE_ALLOC, '0, '0, '0);                 // null wins over full
    send_op(MODE_LOOKUP, '1, gen_t'(1), '0);
    send_op(MODE_DROP, idx_t'(5), slot_gen[5], '0);
    send_op(MODE_ALLOC, '0, '0, '1);                 // back into slot 5
    wait_drained();
  endtask

  task automatic test_clear();
    send_op(MODE_CLEAR, 6'h15, 16'hAAAA, 32'h5555_5555);
    send_op(MODE_LOOKUP, idx_t'(1), gen_t'(1), '0);   // not in use after clear
    send_op(MODE_ALLOC, '0, '0, 32'hDEAD_0001);
    send_op(MODE_LOOKUP, idx_t'(1), gen_t'(1), '0);   // old handle matches again
    send_op(MODE_DROP, idx_t'(1), gen_t'(1), '0);
    wait_drained();
  endtask

  // cycle one slot through a run of generations back to back
  task automatic test_generation_bump();
    idle_on = 1'b0;
    send_op(MODE_CLEAR, '0, '0, '0);
    repeat (GenSteps) begin
      send_op(MODE_ALLOC, '0, '0, pay_t'($urandom) | pay_t'(1));
      send_op(MODE_DROP, idx_t'(1), slot_gen[1], '0);
    end
    send_op(MODE_ALLOC, '0, '0, '1);
    send_op(MODE_LOOKUP, idx_t'(1), gen_t'(GenSteps + 1), '0);
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_random_traffic(int unsigned n_items);
    int unsigned alloc_pct;
    int unsigned roll;
    idx_t        idx;
    gen_t        g;
    pay_t        p;
    mode_e       m;
    alloc_pct = 40;
    for (int unsigned i = 0; i < n_items; i++) begin
      // shift the alloc/drop balance so the table both fills and empties
      if (i % 100 == 0) alloc_pct = $urandom_range(60, 20);
      idle_on = !(i >= n_items / 2 && i < n_items / 2 + 150);
      idx = idx_t'($urandom);
      g   = gen_t'($urandom);
      p   = pay_t'($urandom);
      roll = $urandom_range(99);
      if (roll < 8) begin
        m = mode_e'($urandom_range(3));
        if (m == MODE_CLEAR && $urandom_range(3) != 0) m = MODE_LOOKUP;
        send_op(m, idx, g, p);
      end else begin
        if (high_mark > 1) begin
          idx = idx_t'($urandom_range(high_mark - 1, 1));
          g   = slot_gen[idx];
          if ($urandom_range(9) == 0) g = g ^ gen_t'(1 << $urandom_range(GenW - 1));
        end
        roll = $urandom_range(99);
        if (roll < alloc_pct) begin
          if ($urandom_range(32) == 0) p = '0;
          send_op(MODE_ALLOC, idx, g, p);
        end else if (roll < alloc_pct + (100 - alloc_pct) / 2) begin
          send_op(MODE_LOOKUP, idx, g, p);
        end else begin
          send_op(MODE_DROP, idx, g, p);
        end
      end
    end
    idle_on = 1'b1;
    wait_drained();
  endtask

  initial begin
    foreach (slot_pay[k]) begin
      slot_pay[k] = '0;
      slot_gen[k] = '0;
      free_stk[k] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_alloc_lookup();
    test_drop_reuse();
    test_full_table();
    test_clear();
    test_generation_bump();
    test_random_traffic(720);

    $display("%0d transactions checked: %0d ok, %0d table full, %0d stale, %0d null payload",
             rsp_cnt, ok_cnt, full_cnt, stale_cnt, null_cnt);
    $display("generation wrapped %0d times, %0d mismatches", wrap_cnt, err_cnt);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

@@ generational_handle_allocator_core.f @@
rtl/gha_pkg.sv
rtl/gha_slot_store.sv
rtl/generational_handle_allocator_core.sv
tb/tb.sv
